[hw/rtl/b64_pkg.sv]
// Shared types and constants of the Base64 stream encoder.
// Holds the command passed from the front end to the back end and the alphabet lookup.
// No dependencies.
package b64_pkg;

    localparam logic [1:0] PH_0 = 2'd0;
    localparam logic [1:0] PH_1 = 2'd1;
    localparam logic [1:0] PH_2 = 2'd2;

    localparam logic [6:0] PAD_CHAR = 7'h3D;

    typedef struct packed {
        logic [3:0][6:0] chars;
        logic [1:0]      last_idx;
        logic            fin;
    } t_cmd;

    function automatic logic [6:0] sym(input logic [5:0] idx);
        logic [6:0] v;
        v = {1'b0, idx};
        if (idx < 6'd26) begin
            sym = 7'h41 + v;
        end else if (idx < 6'd52) begin
            sym = 7'h61 + v - 7'd26;
        end else if (idx < 6'd62) begin
            sym = 7'h30 + v - 7'd52;
        end else if (idx == 6'd62) begin
            sym = 7'h2B;
        end else begin
            sym = 7'h2F;
        end
    endfunction

endpackage

[hw/rtl/base64_stream_encoder.sv]
// Base64 stream encoder, top level: front end, command queue and back end.
// A beat's first character is held in a queue entry and then in the output register.
// Throughput: one character per cycle while the sink is ready, set by the single-character
// output register; a byte yields one to four characters, three steady bytes yield four.
// Reset: synchronous, active low; clears group phase, carried bits, queue and output valid.
module base64_stream_encoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,  // data_byte
    input  logic       i_s_tlast,  // final_byte
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,  // text_char, zero-filled to a byte
    output logic       o_m_tlast,  // run_last
    output logic       o_m_tuser   // message_last
);
    import b64_pkg::*;

    t_cmd push_cmd, head_cmd;
    logic push, pop, q_empty, q_full;

    b64_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    b64_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    b64_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head_cmd),
        .i_empty    (q_empty),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

[hw/rtl/b64_front.sv]
// Front end of the Base64 stream encoder: accepts bytes and turns each into a command.
// Keeps the group phase and carried bits; depends on b64_pkg.
module b64_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic [7:0]    i_s_tdata,  // data_byte
    input  logic          i_s_tlast,  // final_byte
    input  logic          i_q_full,
    output logic          o_push,
    output b64_pkg::t_cmd o_cmd
);
    import b64_pkg::*;

    logic [1:0] r_phase, n_phase;
    logic [3:0] r_carry, n_carry;
    logic       fin;
    logic [7:0] b;

    assign fin        = i_s_tlast;
    assign b          = i_s_tdata;
    assign o_s_tready = !i_q_full;
    assign o_push     = i_s_tvalid && !i_q_full;

    always_comb begin
        o_cmd.chars    = '{default: PAD_CHAR};
        o_cmd.last_idx = 2'd0;
        o_cmd.fin      = fin;
        n_phase        = r_phase;
        n_carry        = r_carry;
        case (r_phase)
            PH_1: begin
                o_cmd.chars[0] = sym({r_carry[1:0], b[7:4]});
                n_carry        = b[3:0];
                n_phase        = PH_2;
                if (fin) begin
                    o_cmd.chars[1] = sym({b[3:0], 2'b00});
                    o_cmd.last_idx = 2'd2;
                end
            end
            PH_2: begin
                o_cmd.chars[0] = sym({r_carry, b[7:6]});
                o_cmd.chars[1] = sym(b[5:0]);
                o_cmd.last_idx = 2'd1;
                n_carry        = 4'd0;
                n_phase        = PH_0;
            end
            default: begin
                o_cmd.chars[0] = sym(b[7:2]);
                n_carry        = {2'b00, b[1:0]};
                n_phase        = PH_1;
                if (fin) begin
                    o_cmd.chars[1] = sym({b[1:0], 4'b0000});
                    o_cmd.last_idx = 2'd3;
                end
            end
        endcase
        if (fin) begin
            n_phase = PH_0;
            n_carry = 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_0;
            r_carry <= 4'd0;
        end else if (o_push) begin
            r_phase <= n_phase;
            r_carry <= n_carry;
        end
    end

endmodule

[hw/rtl/b64_queue.sv]
// Short command queue between the front and back ends of the Base64 encoder.
// Register-based FIFO with the head visible combinationally; depends on b64_pkg.
module b64_queue #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  b64_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output b64_pkg::t_cmd o_head,
    output logic          o_empty,
    output logic          o_full
);
    import b64_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          push, pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == FULL_CNT);
    assign o_head  = r_mem[r_rd];
    assign push    = i_push && !o_full;
    assign pop     = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[hw/rtl/b64_back.sv]
// Back end of the Base64 encoder: emits the characters of each queued command in turn.
// Drives the registered output stream; depends on b64_pkg.
module b64_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  b64_pkg::t_cmd i_head,
    input  logic          i_empty,
    output logic          o_pop,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [7:0]    o_m_tdata,  // text_char, zero-filled to a byte
    output logic          o_m_tlast,  // run_last
    output logic          o_m_tuser   // message_last
);
    import b64_pkg::*;

    logic [1:0] r_k;
    logic       r_valid;
    logic [6:0] r_char;
    logic       r_last, r_user;
    logic       slot_free, fire, at_last;

    assign slot_free = !r_valid || i_m_tready;
    assign fire      = slot_free && !i_empty;
    assign at_last   = (r_k == i_head.last_idx);
    assign o_pop     = fire && at_last;

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {1'b0, r_char};
    assign o_m_tlast  = r_last;
    assign o_m_tuser  = r_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_k     <= 2'd0;
        end else begin
            if (slot_free) begin
                r_valid <= !i_empty;
            end
            if (fire) begin
                r_k <= at_last ? 2'd0 : r_k + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_char <= i_head.chars[r_k];
            r_last <= at_last;
            r_user <= at_last && i_head.fin;
        end
    end

endmodule
